// ===== rtl/swtm_pkg.sv =====
package swtm_pkg;

    // field widths
    localparam int ELAPSED_W = 32;
    localparam int WORK_W    = 36;
    localparam int DUR_W     = 32;
    localparam int IDLE_W    = 33;
    localparam int SPEED_W   = 61;
    localparam int COUNT_W   = 6;
    localparam int LIMIT_W   = 16;
    localparam int RING_W    = WORK_W + DUR_W;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    // APB
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register indexes
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_STALE_LIMIT   = 1'b1;

    // defaults and scale factors
    localparam int DEF_MAX_WINDOW   = 32;
    localparam logic [COUNT_W-1:0] DEF_WINDOW_LENGTH = 6'd32;
    localparam logic [LIMIT_W-1:0] DEF_STALE_LIMIT   = 16'd5000;
    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam logic [9:0]  US_PER_MS = 10'd1000;

endpackage

// ===== rtl/swtm_ring.sv =====
module swtm_ring
    import swtm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WINDOW,
    parameter int AW    = 5
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [RING_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [RING_W-1:0] rd_data
);

    // {duration, work} per round
    logic [RING_W-1:0] mem [DEPTH];
    logic [RING_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/swtm_div.sv =====
module swtm_div
    import swtm_pkg::*;
#(
    parameter int WT_W = 42,
    parameter int DT_W = 38
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WT_W-1:0]    work_total,
    input  logic [DT_W-1:0]    dur_total,
    output logic               done,
    output logic [SPEED_W-1:0] quot
);

    localparam int NUM_W = WT_W + 20;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int REM_W = DT_W + 1;

    localparam logic D_IDLE = 1'b0;
    localparam logic D_RUN  = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DT_W-1:0]   den_reg, den_next;
    logic [REM_W-1:0]  shifted;
    logic [REM_W:0]    trial;

    // restoring division, one quotient bit per cycle; quotient shifts into num_reg
    assign shifted = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    num_next   = NUM_W'(work_total * US_PER_S);
                    den_next   = dur_total;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (trial[REM_W])
                begin
                    rem_next = shifted;
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = trial[REM_W-1:0];
                    num_next = {num_reg[NUM_W-2:0], 1'b1};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // saturate to the speed field
    generate
        if (NUM_W > SPEED_W)
        begin : g_sat
            assign quot = (|num_reg[NUM_W-1:SPEED_W]) ? {SPEED_W{1'b1}}
                                                       : num_reg[SPEED_W-1:0];
        end
        else
        begin : g_ext
            assign quot = SPEED_W'(num_reg);
        end
    endgenerate

    assign done = done_reg;

endmodule

// ===== rtl/sliding_window_throughput_meter.sv =====
// Sliding-window throughput meter.
// Input stream (s_*): one beat per timing report. s_tdata carries elapsed_us
// and work_amount, s_tuser the round_done flag. Output stream (m_*): one beat
// per input beat with speed (work units per second), window_count and, in
// m_tuser, the stale flag.
// APB port: window_length at 0x0 (writing it empties the window), stale_limit_ms
// at 0x4. Write only while no beat is in flight.
// Round (work, duration) pairs live in a synchronous ring memory. A push into
// a full window first reads the evicted entry in an extra evict state.
// Most of a beat's time goes to the bit-serial divider that forms
// work_total * 1e6 / duration_total; stale results and an empty window
// skip the divider. One beat is in work at a time; s_tready is high only
// between beats.
// The result sits in an output register: a stalled receiver holds it there,
// and the next beat is accepted and worked on meanwhile, waiting only to hand
// its own result over.
// Reset: window empty, idle time zero, window_length 32 (clamped to
// MAX_WINDOW), stale_limit_ms 5000; ring contents are not cleared, the
// window count keeps stale entries from ever being read.
module sliding_window_throughput_meter
    import swtm_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // APB
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] elapsed_us, [67:32] work_amount
    input  logic                 s_tuser,   // [0] round_done
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [60:0] speed, [66:61] window_count
    output logic                 m_tuser    // [0] stale
);

    // largest usable window: the length register is 6 bits
    localparam int MAXLEN = (MAX_WINDOW < 63) ? MAX_WINDOW : 63;
    localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PW     = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
    localparam int SUM_X  = $clog2(MAXLEN + 1);
    localparam int WT_W   = WORK_W + SUM_X;
    localparam int DT_W   = DUR_W + SUM_X;
    localparam logic [COUNT_W-1:0] MAXLEN_C = COUNT_W'(MAXLEN);

    // control states
    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_EVICT = 3'd1;
    localparam logic [2:0] T_CALC  = 3'd2;
    localparam logic [2:0] T_DIV   = 3'd3;
    localparam logic [2:0] T_OUT   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  len_reg, len_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]       oldest_reg, oldest_next;
    logic [WT_W-1:0]     wt_reg, wt_next;
    logic [DT_W-1:0]     dt_reg, dt_next;
    logic [IDLE_W-1:0]   idle_reg, idle_next;
    logic                stale_reg, stale_next;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic                out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]  out_speed_reg, out_speed_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                out_stale_reg, out_stale_next;
    logic [WORK_W-1:0]   pend_work_reg, pend_work_next;
    logic [DUR_W-1:0]    pend_dur_reg, pend_dur_next;

    // beat decode
    logic [ELAPSED_W-1:0] in_elapsed;
    logic [WORK_W-1:0]    in_work;
    logic                 in_done;
    logic                 accept;
    logic                 cfg_wr;
    logic                 cfg_idx;

    logic [IDLE_W:0]      idle_sum;
    logic [IDLE_W-1:0]    idle_sat;
    logic [DUR_W-1:0]     dur_in;
    logic                 push;
    logic                 full;
    logic [PW-1:0]        slot_sum;
    logic [PW-1:0]        slot_wrap;
    logic [PW-1:0]        oldest_inc;
    logic [COUNT_W-1:0]   len_clamped;
    logic [26:0]          stale_thr;
    logic                 out_free;

    // ring and divider hookup
    logic                ring_wr_en;
    logic [AW-1:0]       ring_wr_addr;
    logic [RING_W-1:0]   ring_wr_data;
    logic                ring_rd_en;
    logic [RING_W-1:0]   ring_rd_data;
    logic [WORK_W-1:0]   old_work;
    logic [DUR_W-1:0]    old_dur;
    logic                div_start;
    logic                div_done;
    logic [SPEED_W-1:0]  div_quot;

    assign in_elapsed = s_tdata[ELAPSED_W-1:0];
    assign in_work    = s_tdata[ELAPSED_W +: WORK_W];
    assign in_done    = s_tuser;
    assign s_tready   = (state_reg == T_IDLE);
    assign accept     = s_tvalid && s_tready;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_WINDOW_LENGTH: prdata = APB_DW'(len_reg);
            REG_STALE_LIMIT:   prdata = APB_DW'(limit_reg);
            default:           prdata = '0;
        endcase
    end

    // only the low 6 bits count: 0 acts as 1, anything past MAXLEN (ring depth, at most 63) as MAXLEN
    always_comb
    begin
        priority if (pwdata[COUNT_W-1:0] == '0)
        begin
            len_clamped = COUNT_W'(1);
        end
        else if (pwdata[COUNT_W-1:0] > MAXLEN_C)
        begin
            len_clamped = MAXLEN_C;
        end
        else
        begin
            len_clamped = pwdata[COUNT_W-1:0];
        end
    end

    // idle time, saturating at 33 bits; the stored duration saturates at 32
    assign idle_sum = {1'b0, idle_reg} + (IDLE_W + 1)'(in_elapsed);
    assign idle_sat = idle_sum[IDLE_W] ? {IDLE_W{1'b1}} : idle_sum[IDLE_W-1:0];
    assign dur_in   = idle_sat[IDLE_W-1] ? {DUR_W{1'b1}} : idle_sat[DUR_W-1:0];
    assign push     = in_done && (idle_sat != '0);
    assign full     = (count_reg >= len_reg);

    // free slot = (oldest + count) mod length; the sum stays below twice the length
    assign slot_sum   = PW'(oldest_reg) + PW'(count_reg);
    assign slot_wrap  = (slot_sum >= PW'(len_reg)) ? (slot_sum - PW'(len_reg)) : slot_sum;
    assign oldest_inc = PW'(oldest_reg) + PW'(1);

    // floor(idle/1000) > limit  <=>  idle >= (limit+1)*1000
    assign stale_thr = 27'(({1'b0, limit_reg} + 17'd1) * US_PER_MS);

    assign old_work = ring_rd_data[WORK_W-1:0];
    assign old_dur  = ring_rd_data[WORK_W +: DUR_W];

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        limit_next     = limit_reg;
        count_next     = count_reg;
        oldest_next    = oldest_reg;
        wt_next        = wt_reg;
        dt_next        = dt_reg;
        idle_next      = idle_reg;
        stale_next     = stale_reg;
        speed_next     = speed_reg;
        pend_work_next = pend_work_reg;
        pend_dur_next  = pend_dur_reg;
        out_speed_next = out_speed_reg;
        out_count_next = out_count_reg;
        out_stale_next = out_stale_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ring_wr_en     = 1'b0;
        ring_wr_addr   = slot_wrap[AW-1:0];
        ring_wr_data   = {dur_in, in_work};
        ring_rd_en     = 1'b0;
        div_start      = 1'b0;

        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WINDOW_LENGTH:
                begin
                    len_next    = len_clamped;
                    count_next  = '0;
                    oldest_next = '0;
                    wt_next     = '0;
                    dt_next     = '0;
                end
                REG_STALE_LIMIT:
                begin
                    limit_next = pwdata[LIMIT_W-1:0];
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    idle_next      = in_done ? '0 : idle_sat;
                    pend_work_next = in_work;
                    pend_dur_next  = dur_in;
                    state_next     = T_CALC;
                    if (push && full)
                    begin
                        // fetch the entry that drops out
                        ring_rd_en = 1'b1;
                        state_next = T_EVICT;
                    end
                    else if (push)
                    begin
                        ring_wr_en = 1'b1;
                        wt_next    = wt_reg + WT_W'(in_work);
                        dt_next    = dt_reg + DT_W'(dur_in);
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            T_EVICT:
            begin
                ring_wr_en   = 1'b1;
                ring_wr_addr = oldest_reg;
                ring_wr_data = {pend_dur_reg, pend_work_reg};
                wt_next      = wt_reg - WT_W'(old_work) + WT_W'(pend_work_reg);
                dt_next      = dt_reg - DT_W'(old_dur) + DT_W'(pend_dur_reg);
                oldest_next  = (oldest_inc >= PW'(len_reg)) ? '0 : oldest_inc[AW-1:0];
                state_next   = T_CALC;
            end
            T_CALC:
            begin
                stale_next = (idle_reg >= IDLE_W'(stale_thr));
                if ((idle_reg >= IDLE_W'(stale_thr)) || (dt_reg == '0))
                begin
                    speed_next = '0;
                    state_next = T_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = T_DIV;
                end
            end
            T_DIV:
            begin
                if (div_done)
                begin
                    speed_next = div_quot;
                    state_next = T_OUT;
                end
            end
            T_OUT:
            begin
                if (out_free)
                begin
                    out_speed_next = speed_reg;
                    out_count_next = count_reg;
                    out_stale_next = stale_reg;
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            len_reg       <= (DEF_WINDOW_LENGTH > MAXLEN_C) ? MAXLEN_C : DEF_WINDOW_LENGTH;
            limit_reg     <= DEF_STALE_LIMIT;
            count_reg     <= '0;
            oldest_reg    <= '0;
            wt_reg        <= '0;
            dt_reg        <= '0;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            wt_reg        <= wt_next;
            dt_reg        <= dt_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stale_reg     <= stale_next;
        speed_reg     <= speed_next;
        pend_work_reg <= pend_work_next;
        pend_dur_reg  <= pend_dur_next;
        out_speed_reg <= out_speed_next;
        out_count_reg <= out_count_next;
        out_stale_reg <= out_stale_next;
    end

    swtm_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_addr (oldest_reg),
        .rd_data (ring_rd_data)
    );

    swtm_div #(
        .WT_W (WT_W),
        .DT_W (DT_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .work_total (wt_reg),
        .dur_total  (dt_reg),
        .done       (div_done),
        .quot       (div_quot)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - SPEED_W - COUNT_W){1'b0}}, out_count_reg, out_speed_reg};
    assign m_tuser  = out_stale_reg;

endmodule
